@@ design/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/dss_pkg.sv @@
`timescale 1ns / 1ps

package dss_pkg;

  localparam int RAW_W          = 8;
  localparam int TIME_W         = 32;
  localparam int THR_W          = 8;
  localparam int IVL_W          = 16;
  localparam int POS_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int INPUT_BITS_DEF = 8;

  localparam logic [THR_W-1:0] THR_RESET       = 8'd3;
  localparam logic [IVL_W-1:0] IVL_RESET       = 16'd10;
  localparam logic [RAW_W-1:0] CANDIDATE_RESET = 8'hFF;

  localparam logic signed [POS_W-1:0] POS_NONE  = 5'sd0;
  localparam logic signed [POS_W-1:0] POS_MULTI = -5'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_INTERVAL = 2'd1
  } cfg_idx_t;

endpackage

@@ design/debounced_selector_sampler_core.sv @@
`timescale 1ns / 1ps
// path: an accepted item goes through the input register, then the result register
// throughput: one item per clock while out_stall is low; the debounce state loop closes
//   through a single register stage, so each item sees the state left by the one before it
// reset (rst_n low, synchronous): debounce state cleared, candidate to all ones,
//   thresholds back to 3 samples / 10 ticks, both pipeline stages emptied

`include "assert_macros.svh"

module debounced_selector_sampler_core import dss_pkg::*; #(
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [TIME_W-1:0]           in_now_time,
  input  logic [RAW_W-1:0]            in_raw_sample,
  input  logic                        in_initialize,
  input  logic                        in_consume_change,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_W-1:0]     out_position,
  output logic                        out_changed,
  output logic [RAW_W-1:0]            out_stable_value,
  output logic [RAW_W-1:0]            out_last_raw,
  output logic                        out_sampled
);

  // only the low selector bits are used, never more than a byte
  localparam int SEL_W = (INPUT_BITS < RAW_W) ? INPUT_BITS : RAW_W;

  // config registers
  logic [THR_W-1:0]  thr_r;
  logic [IVL_W-1:0]  ivl_r;

  // input register
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [SEL_W-1:0]  s1_raw_r;
  logic              s1_init_r;
  logic              s1_consume_r;

  // debounce state
  logic [SEL_W-1:0]  stable_r,  stable_nxt;
  logic [RAW_W-1:0]  cand_r,    cand_nxt;
  logic [THR_W-1:0]  cnt_r,     cnt_nxt;
  logic [TIME_W-1:0] last_r,    last_nxt;
  logic              pend_r,    pend_nxt;

  // result register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_position_r;
  logic                    out_changed_r;
  logic [RAW_W-1:0]        out_stable_r;
  logic [RAW_W-1:0]        out_last_raw_r;
  logic                    out_sampled_r;

  logic                    adv;
  logic                    in_acc;
  logic                    took;
  logic                    reported;
  logic [RAW_W-1:0]        raw_ext;
  logic [TIME_W-1:0]       elapsed;
  logic [THR_W-1:0]        cnt_inc;
  logic signed [POS_W-1:0] pos;

  // the item in the input register moves on whenever the result register is free
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign raw_ext = RAW_W'(s1_raw_r);
  // wrapping time difference since the last sample
  assign elapsed = s1_now_r - last_r;
  // count up toward the threshold, saturating there
  assign cnt_inc = (cnt_r < thr_r) ? cnt_r + THR_W'(1) : cnt_r;

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = cand_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    took       = 1'b0;
    if (s1_init_r) begin
      // start-up load: take the input as already settled
      stable_nxt = s1_raw_r;
      cand_nxt   = raw_ext;
      cnt_nxt    = thr_r;
      last_nxt   = s1_now_r;
      pend_nxt   = 1'b0;
      took       = 1'b1;
    end else if (elapsed >= TIME_W'(ivl_r)) begin
      last_nxt = s1_now_r;
      took     = 1'b1;
      if (raw_ext == cand_r) begin
        cnt_nxt = cnt_inc;
        // candidate qualified and different from what we hold: accept it
        if ((cnt_inc >= thr_r) && (s1_raw_r != stable_r)) begin
          stable_nxt = s1_raw_r;
          pend_nxt   = 1'b1;
        end
      end else begin
        // new candidate, restart qualification
        cand_nxt = raw_ext;
        cnt_nxt  = THR_W'(1);
      end
    end
    // flag is reported before an optional read-clear
    reported = pend_nxt;
    if (s1_consume_r) begin
      pend_nxt = 1'b0;
    end
  end

  dss_pos_decode #(
    .SEL_W (SEL_W)
  ) u_pos_decode (
    .value (stable_nxt),
    .pos   (pos)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      ivl_r       <= IVL_RESET;
      s1_valid_r  <= 1'b0;
      stable_r    <= '0;
      cand_r      <= CANDIDATE_RESET;
      cnt_r       <= '0;
      last_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: thr_r <= cfg_wdata[THR_W-1:0];
          CFG_INTERVAL: ivl_r <= cfg_wdata[IVL_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        stable_r    <= stable_nxt;
        cand_r      <= cand_nxt;
        cnt_r       <= cnt_nxt;
        last_r      <= last_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r     <= in_now_time;
      s1_raw_r     <= in_raw_sample[SEL_W-1:0];
      s1_init_r    <= in_initialize;
      s1_consume_r <= in_consume_change;
    end
    if (adv) begin
      out_position_r <= pos;
      out_changed_r  <= reported;
      out_stable_r   <= RAW_W'(stable_nxt);
      out_last_raw_r <= cand_nxt;
      out_sampled_r  <= took;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_changed      = out_changed_r;
  assign out_stable_value = out_stable_r;
  assign out_last_raw     = out_last_raw_r;
  assign out_sampled      = out_sampled_r;

  // checks
  `DSS_ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r)
  `DSS_ASSERT_NEXT(a_result_follows, clk, rst_n, adv, out_valid_r)
  `DSS_ASSERT_NEXT(a_init_clears_change, clk, rst_n, adv && s1_init_r, !out_changed_r)
  `DSS_ASSERT_NEXT(a_idle_keeps_time, clk, rst_n, adv && !took, $stable(last_r))

endmodule

@@ design/dss_pos_decode.sv @@
`timescale 1ns / 1ps

module dss_pos_decode import dss_pkg::*; #(
  parameter int SEL_W = INPUT_BITS_DEF
) (
  input  logic [SEL_W-1:0]        value,
  output logic signed [POS_W-1:0] pos
);

  localparam int CNT_W = $clog2(SEL_W + 1);

  logic [CNT_W-1:0]        ones;
  logic signed [POS_W-1:0] last_pos;

  always_comb begin
    ones     = '0;
    last_pos = POS_NONE;
    for (int i = 0; i < SEL_W; i++) begin
      if (value[i]) begin
        ones     = ones + CNT_W'(1);
        last_pos = POS_W'(i + 1);
      end
    end
    if (ones == '0) begin
      pos = POS_NONE;
    end else if (ones != CNT_W'(1)) begin
      pos = POS_MULTI;
    end else begin
      pos = last_pos;
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import dss_pkg::*;

  // index past the end of the register list, the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  // one input item as presented on the in_ ports
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [RAW_W-1:0]  raw;
    logic              init;
    logic              consume;
  } sample_t;

  // one result item as seen on the out_ ports
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    changed;
    logic [RAW_W-1:0]        stable;
    logic [RAW_W-1:0]        candidate;
    logic                    sampled;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_now_time = '0;
  logic [RAW_W-1:0]  in_raw_sample = '0;
  logic              in_initialize = 1'b0;
  logic              in_consume_change = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic                    out_changed;
  logic [RAW_W-1:0]        out_stable_value;
  logic [RAW_W-1:0]        out_last_raw;
  logic                    out_sampled;

  debounced_selector_sampler_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_now_time       (in_now_time),
    .in_raw_sample     (in_raw_sample),
    .in_initialize     (in_initialize),
    .in_consume_change (in_consume_change),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_changed       (out_changed),
    .out_stable_value  (out_stable_value),
    .out_last_raw      (out_last_raw),
    .out_sampled       (out_sampled)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be offered, and reports still owed by the block
  sample_t sample_queue[$];
  report_t pending_reports[$];

  // mirror of the register file
  logic [THR_W-1:0] thr_cfg = THR_RESET;
  logic [IVL_W-1:0] ivl_cfg = IVL_RESET;

  // mirror of the debounce state
  logic [RAW_W-1:0]  acc_byte = '0;
  logic [RAW_W-1:0]  cand_byte = CANDIDATE_RESET;
  logic [THR_W-1:0]  hit_count = '0;
  logic [TIME_W-1:0] sampled_at = '0;
  logic              chg_flag = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  logic        item_taken = 1'b0;

  // running tick used to build time stamps for the random part
  logic [TIME_W-1:0] tick_now = '0;

  // stable byte to position: 1..8 for a single set bit, none, or several
  function automatic logic signed [POS_W-1:0] decode_selector(input logic [RAW_W-1:0] v);
    int ones;
    logic signed [POS_W-1:0] pos;
    ones = 0;
    pos = POS_NONE;
    for (int b = 0; b < RAW_W; b++) begin
      if (v[b]) begin
        ones++;
        pos = POS_W'(b + 1);
      end
    end
    if (ones > 1) pos = POS_MULTI;
    return pos;
  endfunction

  // advance the debounce mirror by one item and return the report it owes
  function automatic report_t debounce_step(input sample_t s);
    report_t r;
    logic took;
    took = 1'b0;
    if (s.init) begin
      // start-up load, count full, flag cleared
      acc_byte = s.raw;
      cand_byte = s.raw;
      hit_count = thr_cfg;
      sampled_at = s.now;
      chg_flag = 1'b0;
      took = 1'b1;
    end else if (TIME_W'(s.now - sampled_at) >= TIME_W'(ivl_cfg)) begin
      // wrapping elapsed-time test
      sampled_at = s.now;
      took = 1'b1;
      if (s.raw == cand_byte) begin
        if (hit_count < thr_cfg) hit_count = hit_count + THR_W'(1);
        if (hit_count >= thr_cfg && s.raw != acc_byte) begin
          acc_byte = s.raw;
          chg_flag = 1'b1;
        end
      end else begin
        cand_byte = s.raw;
        hit_count = THR_W'(1);
      end
    end
    // the flag is reported before any read-clear
    r.changed = chg_flag;
    if (s.consume) chg_flag = 1'b0;
    r.position = decode_selector(acc_byte);
    r.stable = acc_byte;
    r.candidate = cand_byte;
    r.sampled = took;
    return r;
  endfunction

  // item accept point: predict from the item the block just took
  always @(posedge clk) begin
    item_taken = rst_n && in_valid && !in_stall;
    if (item_taken)
      pending_reports.push_back(debounce_step({in_now_time, in_raw_sample,
                                               in_initialize, in_consume_change}));
  end

  // sender: bursts of random length, random gaps in between
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    sample_t nxt;
    if (rst_n && (!in_valid || item_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        nxt = sample_queue.pop_front();
        in_now_time <= nxt.now;
        in_raw_sample <= nxt.raw;
        in_initialize <= nxt.init;
        in_consume_change <= nxt.consume;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          // about a third of bursts run straight into the next one
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked anew whenever its mode counter runs out, plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_left = 64;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AFTER && in_valid) begin
      // stop draining long enough for the block to back up to its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = 64;
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= mode_left[0];
      endcase
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    report_t want;
    report_t seen;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      seen = {out_position, out_changed, out_stable_value, out_last_raw, out_sampled};
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result pos=%0d chg=%0b stable=%h last=%h smp=%0b",
                   $time, seen.position, seen.changed, seen.stable, seen.candidate,
                   seen.sampled);
      end else begin
        want = pending_reports.pop_front();
        if (seen.position !== want.position || seen.changed !== want.changed ||
            seen.stable !== want.stable || seen.candidate !== want.candidate ||
            seen.sampled !== want.sampled) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result %0d exp pos=%0d chg=%0b stable=%h last=%h smp=%0b",
                     $time, results_seen, want.position, want.changed, want.stable,
                     want.candidate, want.sampled);
            $display("%0t: result %0d got pos=%0d chg=%0b stable=%h last=%h smp=%0b",
                     $time, results_seen, seen.position, seen.changed, seen.stable,
                     seen.candidate, seen.sampled);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_item(input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw,
                          input logic init, input logic consume);
    sample_queue.push_back({now, raw, init, consume});
  endtask

  // register write; mirror follows, masked to the register's width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DEBOUNCE: thr_cfg = data[THR_W-1:0];
      CFG_INTERVAL: ivl_cfg = data[IVL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_reports.size() != 0);
  endtask

  // well-formed runs of a target byte with some glitches, time steps around
  // the interval so that most items sample and some fall short
  task automatic queue_random(input int count);
    logic [RAW_W-1:0]  target;
    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] step;
    int run_left;
    target = '0;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: target = RAW_W'(1) << $urandom_range(0, RAW_W - 1);
          5: target = '0;
          6: target = '1;
          default: target = RAW_W'($urandom);
        endcase
        run_left = $urandom_range(1, 2 * int'(thr_cfg) + 8);
      end
      run_left--;
      raw = ($urandom_range(0, 7) == 0) ? RAW_W'($urandom) : target;
      case ($urandom_range(0, 19))
        0: step = $urandom;
        1, 2, 3: step = TIME_W'(ivl_cfg) - 1;
        4, 5: step = $urandom_range(0, int'(ivl_cfg));
        default: step = TIME_W'(ivl_cfg) + $urandom_range(0, 2);
      endcase
      tick_now = tick_now + step;
      add_item(tick_now, raw, $urandom_range(0, 39) == 0, $urandom_range(0, 2) == 0);
    end
  endtask

  // one random phase under a given register setting
  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [IVL_W-1:0] ivl,
                           input logic [TIME_W-1:0] start, input int count);
    write_reg(CFG_DEBOUNCE, {8'($urandom), thr});
    write_reg(CFG_INTERVAL, ivl);
    tick_now = start;
    queue_random(count);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings: 3 samples, 10 ticks
    add_item(32'd0, 8'h01, 1'b0, 1'b0);          // interval not yet elapsed
    add_item(32'd5, 8'h04, 1'b1, 1'b0);          // start-up load
    add_item(32'd7, 8'h04, 1'b1, 1'b1);          // load with nothing to clear
    add_item(32'd17, 8'h04, 1'b0, 1'b0);         // equal to stable, saturated
    add_item(32'd27, 8'h80, 1'b0, 1'b0);         // new candidate
    add_item(32'd36, 8'h80, 1'b0, 1'b0);         // one tick short
    add_item(32'd37, 8'h80, 1'b0, 1'b0);
    add_item(32'd47, 8'h80, 1'b0, 1'b0);         // accepted, top position
    add_item(32'd57, 8'h80, 1'b0, 1'b1);         // reported then cleared
    add_item(32'd67, 8'h80, 1'b0, 1'b0);
    add_item(32'd77, 8'h00, 1'b0, 1'b0);         // no bit set
    add_item(32'd87, 8'h00, 1'b0, 1'b0);
    add_item(32'd97, 8'h00, 1'b0, 1'b0);
    add_item(32'd107, 8'hFF, 1'b0, 1'b0);        // all bits set
    add_item(32'd117, 8'hFF, 1'b0, 1'b0);
    add_item(32'd127, 8'hFF, 1'b0, 1'b1);
    add_item(32'hFFFF_FFF9, 8'h7F, 1'b0, 1'b0);  // time wraps from here on
    add_item(32'h0000_0003, 8'h7F, 1'b0, 1'b0);
    add_item(32'h0000_0002, 8'h7F, 1'b0, 1'b0);  // time going back reads as huge
    add_item(32'hFFFF_FFFF, 8'h01, 1'b1, 1'b0);  // load at the top of the range
    wait_idle();

    // write past the register list, then upper bits that must be dropped
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'hAB05);
    add_item(32'd100, 8'h20, 1'b0, 1'b0);
    add_item(32'd110, 8'h20, 1'b0, 1'b0);        // count 2 of 5
    wait_idle();

    // threshold dropped below the running count
    write_reg(CFG_DEBOUNCE, 16'h0001);
    add_item(32'd120, 8'h20, 1'b0, 1'b0);
    wait_idle();

    // threshold of zero: an equal sample is accepted at once
    write_reg(CFG_DEBOUNCE, 16'hFF00);
    add_item(32'd130, 8'h02, 1'b0, 1'b0);
    add_item(32'd140, 8'h02, 1'b0, 1'b0);
    add_item(32'd150, 8'h40, 1'b1, 1'b0);
    add_item(32'd160, 8'h40, 1'b0, 1'b1);
    wait_idle();

    // random part under several settings, extremes included
    run_phase(8'd1, 16'd0, 32'd1000, 80);
    run_phase(8'd255, 16'd1, 32'h8000_0000, 40);
    run_phase(8'd2, 16'hFFFF, 32'hFFFF_0000, 60);
    run_phase(THR_RESET, IVL_RESET, 32'd5000, 200);   // long hold-off lands here
    run_phase(8'd0, 16'd3, 32'hFFFF_FFC0, 60);
    run_phase(8'd8, 16'd20, $urandom, 75);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
